FILE: hw/rtl/prf_pkg.sv
`timescale 1ns / 1ps

package prf_pkg;

   localparam int PORT_W = 3;
   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;

   // Port table size; the 3-bit port fields address at most eight ports
   localparam int PORTS = 8;

   localparam logic CMD_REPORT = 1'b0;
   localparam logic CMD_PACKET = 1'b1;

   localparam logic [ADDR_W-1:0] ADDR_BCAST = 16'hFFFF;
   localparam logic [ADDR_W-1:0] ADDR_ZERO  = 16'h0000;
   localparam logic [DATA_W-1:0] BYTE_REQ   = 8'h55;
   localparam logic [DATA_W-1:0] BYTE_RET   = 8'hAA;
   localparam logic [DATA_W-1:0] BYTE_ZERO  = 8'h00;
   localparam logic [DATA_W-1:0] BYTE_FULL  = 8'hFF;

   // Cap on sends caused by one request, as a 3-bit send count
   localparam logic [2:0] MAX_SENDS = 3'd7;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_UNKNOWN = 2'd1,
      KIND_NODE    = 2'd2,
      KIND_ROUTER  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SEND_CLIENT_HS  = 2'd0,
      SEND_ROUTER_RET = 2'd1,
      SEND_ECHO       = 2'd2,
      SEND_FORWARD    = 2'd3
   } send_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CTRL_SEND,
      ST_SCAN_NODE,
      ST_SCAN_ROUTER
   } state_type;

   typedef struct packed {
      logic     load_req;
      logic     rd_sel_port;
      logic     apply_report;
      logic     apply_ctrl;
      logic     scan_clear;
      logic     scan_step;
      logic     emit;
      logic     emit_fwd;
      logic     emit_last;
      send_type emit_kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic     in_range;
      logic     is_report;
      logic     entry_active;
      logic     hdr_null;
      logic     dst_bcast;
      logic     ctrl_send;
      send_type ctrl_kind;
      logic     node_hit;
      logic     router_hit;
      logic     router_more;
      logic     scan_end;
      logic     count_max;
      logic     out_free;
   } ctl_status_type;

endpackage

FILE: hw/rtl/prf_ctrl.sv
`timescale 1ns / 1ps

module prf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  prf_pkg::ctl_status_type status,
   output prf_pkg::ctl_cmd_type    cmd
);
   import prf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.emit_kind = SEND_FORWARD;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.rd_sel_port = 1'b1;
            cmd.scan_clear  = 1'b1;
            state_in        = ST_IDLE;
            if (!status.in_range) begin
               state_in = ST_IDLE;
            end else if (status.is_report) begin
               cmd.apply_report = 1'b1;
            end else if (!status.entry_active || status.hdr_null) begin
               state_in = ST_IDLE;
            end else if (status.dst_bcast) begin
               cmd.apply_ctrl = 1'b1;
               if (status.ctrl_send) begin
                  state_in = ST_CTRL_SEND;
               end
            end else begin
               state_in = ST_SCAN_NODE;
            end
         end
         ST_CTRL_SEND: begin
            cmd.emit_kind = status.ctrl_kind;
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN_NODE: begin
            if (status.node_hit) begin
               // hold the scan until the output register frees up
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_fwd  = 1'b1;
                  cmd.emit_last = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (status.scan_end) begin
               cmd.scan_clear = 1'b1;
               state_in       = ST_SCAN_ROUTER;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_SCAN_ROUTER: begin
            if (status.router_hit) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_fwd  = 1'b1;
                  cmd.emit_last = !status.router_more || status.count_max;
                  if (cmd.emit_last || status.scan_end) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.scan_step = 1'b1;
                  end
               end
            end else if (status.scan_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/prf_datapath.sv
`timescale 1ns / 1ps

module prf_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_cmd,
   input  logic [prf_pkg::PORT_W-1:0]     req_port,
   input  logic                           req_present,
   input  logic [prf_pkg::ADDR_W-1:0]     req_dst_addr,
   input  logic [prf_pkg::ADDR_W-1:0]     req_src_addr,
   input  logic [prf_pkg::DATA_W-1:0]     req_data_first,
   input  logic [prf_pkg::DATA_W-1:0]     req_data_second,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [prf_pkg::PORT_W-1:0]     rsp_out_port,
   output logic [1:0]                     rsp_send_kind,
   output logic                           rsp_last,
   input  prf_pkg::ctl_cmd_type           cmd,
   output prf_pkg::ctl_status_type        status
);
   import prf_pkg::*;

   localparam int IW = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(PORTS - 1);

   // Latched request
   logic              cmd_ff;
   logic [PORT_W-1:0] port_ff;
   logic              present_ff;
   logic [ADDR_W-1:0] dst_ff;
   logic [ADDR_W-1:0] src_ff;
   logic [DATA_W-1:0] d0_ff;
   logic [DATA_W-1:0] d1_ff;

   // Port table
   logic              active_ff [PORTS];
   kind_type          kind_ff   [PORTS];
   logic [ADDR_W-1:0] addr_ff   [PORTS];

   logic [IW-1:0]     cnt_ff;
   logic [IW-1:0]     cnt_in;
   logic [2:0]        sent_ff;
   logic [2:0]        sent_in;

   logic              out_valid_ff;
   logic [PORT_W-1:0] out_port_ff;
   send_type          out_kind_ff;
   logic              out_last_ff;

   logic [IW-1:0]     pidx;
   logic [IW-1:0]     rd_idx;
   logic              rd_active;
   kind_type          rd_kind;
   logic [ADDR_W-1:0] rd_addr;
   logic [PORTS-1:0]  router_mask;
   logic [PORTS-1:0]  above_mask;
   logic              is_client;
   logic              is_router_req;
   logic              is_router_ret;
   logic              is_ping;

   assign pidx      = IW'(port_ff);
   assign rd_idx    = cmd.rd_sel_port ? pidx : cnt_ff;
   assign rd_active = active_ff[rd_idx];
   assign rd_kind   = kind_ff[rd_idx];
   assign rd_addr   = addr_ff[rd_idx];

   assign is_client     = (d0_ff == BYTE_REQ) && (d1_ff == BYTE_ZERO);
   assign is_router_req = !is_client && (src_ff == ADDR_BCAST) && (d0_ff == BYTE_REQ);
   assign is_router_ret = !is_client && (src_ff == ADDR_BCAST) && (d0_ff == BYTE_RET);
   assign is_ping       = !is_client && (src_ff == ADDR_ZERO);

   // Routers other than the arrival port, and the part of the scan still ahead
   always_comb begin
      for (int i = 0; i < PORTS; i++) begin
         router_mask[i] = (kind_ff[i] == KIND_ROUTER) && (IW'(i) != pidx);
         above_mask[i]  = IW'(i) > cnt_ff;
      end
   end

   always_comb begin
      status.in_range     = {2'b00, port_ff} < 5'(PORTS);
      status.is_report    = cmd_ff == CMD_REPORT;
      status.entry_active = rd_active;
      status.hdr_null     = (dst_ff == ADDR_ZERO) && (src_ff == ADDR_ZERO);
      status.dst_bcast    = dst_ff == ADDR_BCAST;
      status.ctrl_send    = is_client || is_router_req || is_ping;
      if (is_client) begin
         status.ctrl_kind = SEND_CLIENT_HS;
      end else if (is_router_req) begin
         status.ctrl_kind = SEND_ROUTER_RET;
      end else begin
         status.ctrl_kind = SEND_ECHO;
      end
      status.node_hit    = (rd_kind == KIND_NODE) && (rd_addr == dst_ff);
      status.router_hit  = router_mask[cnt_ff];
      status.router_more = |(router_mask & above_mask);
      status.scan_end    = cnt_ff == LAST_IDX;
      status.count_max   = sent_ff == (MAX_SENDS - 3'd1);
      status.out_free    = !out_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff     <= req_cmd;
         port_ff    <= req_port;
         present_ff <= req_present;
         dst_ff     <= req_dst_addr;
         src_ff     <= req_src_addr;
         d0_ff      <= req_data_first;
         d1_ff      <= req_data_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORTS; i++) begin
            active_ff[i] <= 1'b0;
            kind_ff[i]   <= KIND_NONE;
            addr_ff[i]   <= '0;
         end
      end else if (cmd.apply_report) begin
         active_ff[pidx] <= present_ff;
         kind_ff[pidx]   <= present_ff ? KIND_UNKNOWN : KIND_NONE;
         addr_ff[pidx]   <= '0;
      end else if (cmd.apply_ctrl) begin
         if (is_client) begin
            kind_ff[pidx] <= KIND_NODE;
            addr_ff[pidx] <= src_ff;
         end else if (is_router_req || is_router_ret) begin
            kind_ff[pidx] <= KIND_ROUTER;
         end
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      sent_in = sent_ff;
      if (cmd.scan_clear) begin
         cnt_in = '0;
      end else if (cmd.scan_step) begin
         cnt_in = cnt_ff + IW'(1);
      end
      if (cmd.load_req) begin
         sent_in = '0;
      end else if (cmd.emit) begin
         sent_in = sent_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         sent_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         sent_ff <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_port_ff <= cmd.emit_fwd ? PORT_W'(cnt_ff) : port_ff;
         out_kind_ff <= cmd.emit_kind;
         out_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_port  = out_port_ff;
   assign rsp_send_kind = out_kind_ff;
   assign rsp_last      = out_last_ff;

endmodule

FILE: hw/rtl/port_router_forwarding.sv
`timescale 1ns / 1ps
// Port router forwarding table.
// Request channel (req_valid/req_ready): a port presence report (req_cmd 0)
// or a received packet header (req_cmd 1) with its port, addresses and the
// first two payload bytes. Response channel (rsp_valid/rsp_ready): one item
// per send, carrying the output port, the send kind and a last flag on the
// final send caused by a request. A request that causes no send gives no
// response item.
// A request is taken only in the idle state; one request is worked at a time.
// A report or ignored header ends after the check state; a sending control
// packet also passes the control-send state. A forwarded header walks the
// table one entry per cycle while no send is held: up to PORTS entries for
// the node search, then up to PORTS more for the router flood. One read index
// picks address and kind; the flood sees all kinds. Sends leave through one
// output register; a stalled receiver holds the walk on a send until taken.
// Reset clears the table (all ports inactive, kind none, address zero) and
// drops any pending response.
module port_router_forwarding (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [prf_pkg::PORT_W-1:0] req_port,
   input  logic                       req_present,
   input  logic [prf_pkg::ADDR_W-1:0] req_dst_addr,
   input  logic [prf_pkg::ADDR_W-1:0] req_src_addr,
   input  logic [prf_pkg::DATA_W-1:0] req_data_first,
   input  logic [prf_pkg::DATA_W-1:0] req_data_second,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [prf_pkg::PORT_W-1:0] rsp_out_port,
   output logic [1:0]                 rsp_send_kind,
   output logic                       rsp_last
);
   import prf_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   prf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   prf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_port        (req_port),
      .req_present     (req_present),
      .req_dst_addr    (req_dst_addr),
      .req_src_addr    (req_src_addr),
      .req_data_first  (req_data_first),
      .req_data_second (req_data_second),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_port    (rsp_out_port),
      .rsp_send_kind   (rsp_send_kind),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
